// ===== design/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants, types and the sRGB linearization table for the contrast
// ratio core.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int LUM_FRAC_BITS   = 16;
    localparam int RATIO_FRAC_BITS = 8;

    // Luminance values run from 0 to 1.0 inclusive, so one extra bit.
    localparam int LUM_W  = LUM_FRAC_BITS + 1;
    localparam int PROD_W = 2 * LUM_W;
    // Ratio field width; the ratio never exceeds 21.0.
    localparam int QUO_W  = 13;
    localparam int NUM_W  = LUM_W + RATIO_FRAC_BITS;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int FRONT_STAGES = 4;
    localparam int INFL_W       = $clog2(FRONT_STAGES + 1);

    localparam longint unsigned ONE_L  = 64'd1 << LUM_FRAC_BITS;
    localparam longint unsigned W_RED_L =
        ((64'd2126 << LUM_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint unsigned W_BLUE_L =
        ((64'd722 << LUM_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint unsigned W_GREEN_L = ONE_L - W_RED_L - W_BLUE_L;
    localparam longint unsigned OFS_L =
        ((64'd5 << LUM_FRAC_BITS) + 64'd50) / 64'd100;

    localparam logic [LUM_W-1:0]  W_RED   = LUM_W'(W_RED_L);
    localparam logic [LUM_W-1:0]  W_GREEN = LUM_W'(W_GREEN_L);
    localparam logic [LUM_W-1:0]  W_BLUE  = LUM_W'(W_BLUE_L);
    localparam logic [LUM_W-1:0]  LUM_OFS = LUM_W'(OFS_L);
    localparam logic [PROD_W-1:0] LUM_HALF = PROD_W'(ONE_L >> 1);
    localparam logic [QUO_W-1:0]  RATIO_ONE = QUO_W'(64'd1 << RATIO_FRAC_BITS);

    // Wide enough for (2y-1)^5 * 269025^12 at the largest fraction width.
    localparam int BIG_W = 384;

    typedef logic [LUM_W-1:0] t_lin_table [256];

    // Exact table entry, worked out at elaboration. Above the knee the entry
    // is the largest y with (2y-1)^5 * 269025^12 <= (1000v+14025)^12 * 2^(5F+5),
    // which is the rounded value of 2^F * x^2.4.
    function automatic logic [LUM_W-1:0] lin_entry(input int unsigned v);
        logic [BIG_W-1:0] num12;
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] odd;
        logic [BIG_W-1:0] base;
        logic [LUM_W:0]   lo;
        logic [LUM_W:0]   hi;
        logic [LUM_W:0]   mid;
        longint unsigned  lin;
        if (v <= 10) begin
            lin = ((longint'(v) * 64'd100 << LUM_FRAC_BITS) + 64'd164730) / 64'd329460;
            return LUM_W'(lin);
        end
        num12 = BIG_W'(1);
        den12 = BIG_W'(1);
        base  = BIG_W'(1000 * v + 14025);
        for (int i = 0; i < 12; i++) begin
            num12 = num12 * base;
            den12 = den12 * BIG_W'(269025);
        end
        rhs = num12 << (5 * LUM_FRAC_BITS + 5);
        lo  = '0;
        hi  = (LUM_W + 1)'(ONE_L);
        for (int s = 0; s <= LUM_W; s++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1'b1) >> 1;
                odd = BIG_W'({mid, 1'b0} - 1'b1);
                lhs = den12;
                for (int j = 0; j < 5; j++) begin
                    lhs = lhs * odd;
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1'b1;
                end
            end
        end
        return lo[LUM_W-1:0];
    endfunction

    function automatic t_lin_table build_lin_table();
        t_lin_table tab;
        for (int v = 0; v < 256; v++) begin
            tab[v] = lin_entry(v);
        end
        return tab;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();

    typedef struct packed {
        logic [7:0] second_blue;
        logic [7:0] second_green;
        logic [7:0] second_red;
        logic [7:0] first_blue;
        logic [7:0] first_green;
        logic [7:0] first_red;
    } t_rgb_pair;

    // One classified item: both luminances plus the brighter and darker
    // values with the flare offset already added.
    typedef struct packed {
        logic [LUM_W-1:0] lum2;
        logic [LUM_W-1:0] lum1;
        logic [LUM_W-1:0] hi_ofs;
        logic [LUM_W-1:0] lo_ofs;
    } t_lum_pair;

    typedef struct packed {
        logic [LUM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [LUM_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic [LUM_W-1:0] lum2;
        logic [LUM_W-1:0] lum1;
    } t_div_stage;

endpackage

// ===== design/ccr_front.sv =====
// ----------------------------------------------------------------------------
// ccr_front
// Four-stage luminance pipeline: table lookup, weighting, rounding sum, and
// ordering of the two luminances into brighter and darker.
// ----------------------------------------------------------------------------
module ccr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  ccr_pkg::t_rgb_pair        i_pair,
    output logic                      o_valid,
    output ccr_pkg::t_lum_pair        o_pair,
    output logic [ccr_pkg::INFL_W-1:0] o_inflight
);

    logic [ccr_pkg::FRONT_STAGES-1:0] r_vld;

    logic [ccr_pkg::LUM_W-1:0]  r_lin  [6];
    logic [ccr_pkg::PROD_W-1:0] r_prod [6];
    logic [ccr_pkg::LUM_W-1:0]  r_lum1;
    logic [ccr_pkg::LUM_W-1:0]  r_lum2;
    ccr_pkg::t_lum_pair         r_out;

    logic [7:0]                 chan   [6];
    logic [ccr_pkg::LUM_W-1:0]  weight [6];
    logic [ccr_pkg::PROD_W-1:0] n_sum1;
    logic [ccr_pkg::PROD_W-1:0] n_sum2;
    ccr_pkg::t_lum_pair         n_out;

    always_comb begin
        chan[0] = i_pair.first_red;
        chan[1] = i_pair.first_green;
        chan[2] = i_pair.first_blue;
        chan[3] = i_pair.second_red;
        chan[4] = i_pair.second_green;
        chan[5] = i_pair.second_blue;
        for (int i = 0; i < 2; i++) begin
            weight[3*i]     = ccr_pkg::W_RED;
            weight[3*i + 1] = ccr_pkg::W_GREEN;
            weight[3*i + 2] = ccr_pkg::W_BLUE;
        end
    end

    always_comb begin
        n_sum1 = r_prod[0] + r_prod[1] + r_prod[2] + ccr_pkg::LUM_HALF;
        n_sum2 = r_prod[3] + r_prod[4] + r_prod[5] + ccr_pkg::LUM_HALF;
        n_out.lum1 = r_lum1;
        n_out.lum2 = r_lum2;
        if (r_lum1 > r_lum2) begin
            n_out.hi_ofs = r_lum1 + ccr_pkg::LUM_OFS;
            n_out.lo_ofs = r_lum2 + ccr_pkg::LUM_OFS;
        end else begin
            n_out.hi_ofs = r_lum2 + ccr_pkg::LUM_OFS;
            n_out.lo_ofs = r_lum1 + ccr_pkg::LUM_OFS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ccr_pkg::FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_lin[i]  <= ccr_pkg::LIN_TABLE[chan[i]];
            r_prod[i] <= weight[i] * r_lin[i];
        end
        r_lum1 <= n_sum1[ccr_pkg::LUM_FRAC_BITS +: ccr_pkg::LUM_W];
        r_lum2 <= n_sum2[ccr_pkg::LUM_FRAC_BITS +: ccr_pkg::LUM_W];
        r_out  <= n_out;
    end

    assign o_valid    = r_vld[ccr_pkg::FRONT_STAGES-1];
    assign o_pair     = r_out;
    assign o_inflight = ccr_pkg::INFL_W'($countones(r_vld));

endmodule

// ===== design/ccr_queue.sv =====
// ----------------------------------------------------------------------------
// ccr_queue
// Small first-in first-out buffer between the luminance front and the
// divider back end.
// ----------------------------------------------------------------------------
module ccr_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  ccr_pkg::t_lum_pair       i_data,
    input  logic                     i_pop,
    output ccr_pkg::t_lum_pair       o_head,
    output logic                     o_empty,
    output logic [ccr_pkg::Q_AW:0]   o_count
);

    ccr_pkg::t_lum_pair           r_mem [ccr_pkg::Q_DEPTH];
    logic [ccr_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [ccr_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [ccr_pkg::Q_AW:0]       r_count;
    logic                         pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ===== design/ccr_div.sv =====
// ----------------------------------------------------------------------------
// ccr_div
// Restoring divider, one quotient bit per stage, that forms the contrast
// ratio. The last stage doubles as the output register.
// ----------------------------------------------------------------------------
module ccr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  ccr_pkg::t_lum_pair         i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ccr_pkg::QUO_W-1:0]  o_ratio,
    output logic [ccr_pkg::LUM_W-1:0]  o_lum1,
    output logic [ccr_pkg::LUM_W-1:0]  o_lum2
);

    localparam int LAST = ccr_pkg::QUO_W - 1;
    localparam int PAD  = ccr_pkg::LUM_W - (ccr_pkg::NUM_W - ccr_pkg::QUO_W);

    logic [ccr_pkg::QUO_W-1:0] r_vld;
    ccr_pkg::t_div_stage       r_stg [ccr_pkg::QUO_W];
    ccr_pkg::t_div_stage       stg_in [ccr_pkg::QUO_W];
    ccr_pkg::t_div_stage       n_stg  [ccr_pkg::QUO_W];
    logic                      adv;
    logic [ccr_pkg::NUM_W-1:0] head_num;

    // The whole back end moves together; it stops only while a finished
    // word waits at the output.
    assign adv   = !r_vld[LAST] || i_ready;
    assign o_pop = adv && i_head_valid;

    always_comb begin
        head_num = {i_head.hi_ofs, {ccr_pkg::RATIO_FRAC_BITS{1'b0}}};
        stg_in[0].num  = head_num;
        stg_in[0].den  = i_head.lo_ofs;
        // The quotient fits in QUO_W bits, so the upper numerator bits are
        // already below the divisor.
        stg_in[0].rem  = {{PAD{1'b0}}, head_num[ccr_pkg::NUM_W-1:ccr_pkg::QUO_W]};
        stg_in[0].quo  = '0;
        stg_in[0].lum1 = i_head.lum1;
        stg_in[0].lum2 = i_head.lum2;
        for (int k = 1; k < ccr_pkg::QUO_W; k++) begin
            stg_in[k] = r_stg[k-1];
        end
    end

    for (genvar k = 0; k < ccr_pkg::QUO_W; k++) begin : g_step
        localparam int BIT = ccr_pkg::QUO_W - 1 - k;
        logic [ccr_pkg::LUM_W:0] trial;
        logic                    ge;

        always_comb begin
            trial    = {stg_in[k].rem, stg_in[k].num[BIT]};
            ge       = (trial >= {1'b0, stg_in[k].den});
            n_stg[k] = stg_in[k];
            if (ge) begin
                n_stg[k].rem = ccr_pkg::LUM_W'(trial - {1'b0, stg_in[k].den});
            end else begin
                n_stg[k].rem = trial[ccr_pkg::LUM_W-1:0];
            end
            n_stg[k].quo[BIT] = ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAST-1:0], i_head_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < ccr_pkg::QUO_W; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_ratio = r_stg[LAST].quo;
    assign o_lum1  = r_stg[LAST].lum1;
    assign o_lum2  = r_stg[LAST].lum2;

endmodule

// ===== design/color_contrast_ratio_core.sv =====
// ----------------------------------------------------------------------------
// color_contrast_ratio_core
// Relative luminance of two sRGB colors and their contrast ratio in Q5.8.
//
//  Channel   Direction  Word contents (lowest bits first)
//  s_axis    in         first r/g/b, second r/g/b, 8 bits each
//  m_axis    out        ratio_q8 (13), first_luminance (17),
//                       second_luminance (17), one zero pad bit
//
//  One color pair is accepted every cycle while o_s_tready is high; a pair
//  passes four luminance stages, the queue, then a divider stage per ratio bit.
//  o_s_tready drops only when the queue plus the items still in the
//  luminance stages would fill the eight queue entries.
//  A stalled output holds the whole divider chain; the front keeps running.
//  Reset is synchronous and active low and empties every stage.
// ----------------------------------------------------------------------------
module color_contrast_ratio_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // ratio_q8, first_luminance, second_luminance, zero pad
    output logic [47:0] o_m_tdata
);

    logic                               in_accept;
    logic                               front_valid;
    ccr_pkg::t_lum_pair                 front_pair;
    logic [ccr_pkg::INFL_W-1:0]         inflight;
    ccr_pkg::t_lum_pair                 q_head;
    logic                               q_empty;
    logic [ccr_pkg::Q_AW:0]             q_count;
    logic                               q_pop;
    logic [ccr_pkg::QUO_W-1:0]          ratio;
    logic [ccr_pkg::LUM_W-1:0]          lum1;
    logic [ccr_pkg::LUM_W-1:0]          lum2;
    logic [ccr_pkg::Q_AW+1:0]           committed;

    // Every item already inside the front is owed a queue entry.
    assign committed  = (ccr_pkg::Q_AW + 2)'(q_count) + (ccr_pkg::Q_AW + 2)'(inflight);
    assign o_s_tready = committed < (ccr_pkg::Q_AW + 2)'(ccr_pkg::Q_DEPTH);
    assign in_accept  = i_s_tvalid && o_s_tready;

    ccr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_accept),
        .i_pair     (ccr_pkg::t_rgb_pair'(i_s_tdata)),
        .o_valid    (front_valid),
        .o_pair     (front_pair),
        .o_inflight (inflight)
    );

    ccr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_pair),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ccr_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_ratio      (ratio),
        .o_lum1       (lum1),
        .o_lum2       (lum2)
    );

    assign o_m_tdata = {1'b0, lum2, lum1, ratio};

    // The credit check must keep the queue from ever overflowing.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (ccr_pkg::Q_AW + 2)'(ccr_pkg::Q_DEPTH))
        else $error("queue credit exceeded");

    // A result is always between 1.0 and 21.0.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (ratio >= ccr_pkg::RATIO_ONE) && (ratio <= 13'd5376))
        else $error("ratio out of range");

    // Equal luminances give a ratio of exactly 1.0.
    a_equal_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (lum1 == lum2)) |-> (ratio == ccr_pkg::RATIO_ONE))
        else $error("equal luminances without unit ratio");

    // No pop may happen while the queue is empty.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule
